FILE: rtl/three_level_feedback_scheduler_top_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_TOP_DEFINES_SVH

`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define TLFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that a condition never holds outside reset.
`define TLFS_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TLFS_ASSERT(label, prop, msg)
`define TLFS_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/tlfs_pkg.sv
// Types and constants of the three-level feedback scheduler.
`default_nettype none

package tlfs_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;

    localparam int ID_W   = 16;
    localparam int TIME_W = 16;
    localparam int SVC_W  = 4;
    localparam int LVL_W  = 2;

    localparam logic [SVC_W-1:0] SVC_MAX       = 4'd15;
    localparam logic [SVC_W-1:0] LIMIT_DEFAULT = 4'd2;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_SCHED = 1'b1;

    // Level codes as seen on the ports.
    localparam logic [LVL_W-1:0] LVL_NONE   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd1;
    localparam logic [LVL_W-1:0] LVL_MIDDLE = 2'd2;
    localparam logic [LVL_W-1:0] LVL_TOP    = 2'd3;

    // Internal queue indexes.
    localparam logic [1:0] Q_BOTTOM = 2'd0;
    localparam logic [1:0] Q_MIDDLE = 2'd1;
    localparam logic [1:0] Q_TOP    = 2'd2;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_PENDING  = 3'd2,
        ST_FINISHED = 3'd3,
        ST_IDLE     = 3'd4
    } status_t;

    typedef struct packed {
        logic                 func;
        logic [ID_W-1:0]      proc_id;
        logic [TIME_W-1:0]    run_time;
        logic [LVL_W-1:0]     priority_level;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      served_id;
        logic [LVL_W-1:0]     served_level;
        logic [TIME_W-1:0]    time_left;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]      pid;
        logic [TIME_W-1:0]    rem;
        logic [SVC_W-1:0]     svc;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0]      pid;
        logic [TIME_W-1:0]    rem;
    } bottom_entry_t;

endpackage

`default_nettype wire

FILE: rtl/tlfs_if.sv
// Handshake channels of the scheduler: request, result and configuration.
`default_nettype none

interface tlfs_req_if import tlfs_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tlfs_rsp_if import tlfs_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tlfs_cfg_if import tlfs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SVC_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tlfs_ram.sv
// Generic single-write, single-read RAM with registered, write-first read.
`default_nettype none

module tlfs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // A write to the address being read returns the new word.
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/three_level_feedback_scheduler_top.sv
// Three-level feedback scheduler: three ring-buffer queues and a one-pass serve/add unit.
//
//  Channel  Role     Beat carries
//  -------  -------  ----------------------------------------------------
//  req      sink     func, proc_id, run_time, priority_level
//  rsp      source   status, served_id, served_level, time_left
//  cfg      sink     services_before_demotion (always ready)
//
// One request beat is taken per cycle unless rsp stalls; its result is registered and
// appears on rsp in the cycle after. Each queue RAM always reads the slot that will be the
// head after this edge, so the head entry is ready for the next beat.
// The rate is set by that single head read and tail write per queue.
// Reset empties all queues at once; the RAM contents are never cleared.
// req stalls only while a result waits and rsp is not ready.
`default_nettype none

`include "three_level_feedback_scheduler_top_defines.svh"

module three_level_feedback_scheduler_top import tlfs_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
    input wire logic  clk,
    input wire logic  rst_n,
    tlfs_req_if.sink  req,
    tlfs_rsp_if.source rsp,
    tlfs_cfg_if.sink  cfg
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int TW = CW + 2;

    logic [SVC_W-1:0] limit_reg;
    logic [AW-1:0]    head_reg  [3];
    logic [AW-1:0]    head_next [3];
    logic [CW-1:0]    cnt_reg   [3];
    logic [CW-1:0]    cnt_next  [3];
    logic [AW-1:0]    tail_slot [3];
    logic             push_we   [3];
    entry_t           head_ent  [3];

    logic          rsp_valid_reg;
    rsp_t          rsp_data_reg;
    rsp_t          rsp_data_next;

    logic          in_fire;
    logic [TW-1:0] total;
    logic          full;
    logic          any_held;
    logic [1:0]    add_q;
    logic [1:0]    srv_q;
    entry_t        srv_ent;
    logic [TIME_W-1:0] time_dec;
    logic [SVC_W-1:0]  svc_inc;
    logic [SVC_W-1:0]  limit_eff;
    logic          demote;
    logic          pop_en;
    logic          push_en;
    logic [1:0]    push_q;
    entry_t        push_ent;
    bottom_entry_t bottom_wdata;
    bottom_entry_t bottom_rdata;
    logic [SW-1:0] slot_sum [3];

    assign in_fire   = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign total    = TW'(cnt_reg[0]) + TW'(cnt_reg[1]) + TW'(cnt_reg[2]);
    assign full     = total >= TW'(DEPTH);
    assign any_held = total != '0;

    // Queue RAMs; the read address is the head that the next beat will see.
    tlfs_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_top_ram (
        .clk   (clk),
        .we    (push_we[Q_TOP]),
        .waddr (tail_slot[Q_TOP]),
        .wdata (push_ent),
        .raddr (head_next[Q_TOP]),
        .rdata (head_ent[Q_TOP])
    );

    tlfs_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_middle_ram (
        .clk   (clk),
        .we    (push_we[Q_MIDDLE]),
        .waddr (tail_slot[Q_MIDDLE]),
        .wdata (push_ent),
        .raddr (head_next[Q_MIDDLE]),
        .rdata (head_ent[Q_MIDDLE])
    );

    assign bottom_wdata = '{pid: push_ent.pid, rem: push_ent.rem};

    tlfs_ram #(.WIDTH($bits(bottom_entry_t)), .DEPTH(DEPTH)) u_bottom_ram (
        .clk   (clk),
        .we    (push_we[Q_BOTTOM]),
        .waddr (tail_slot[Q_BOTTOM]),
        .wdata (bottom_wdata),
        .raddr (head_next[Q_BOTTOM]),
        .rdata (bottom_rdata)
    );

    assign head_ent[Q_BOTTOM] = '{pid: bottom_rdata.pid, rem: bottom_rdata.rem, svc: '0};

    // Serve and add decisions.
    always_comb
    begin
        case (req.data.priority_level)
            LVL_BOTTOM: add_q = Q_BOTTOM;
            LVL_MIDDLE: add_q = Q_MIDDLE;
            default:    add_q = Q_TOP;
        endcase

        if (cnt_reg[Q_TOP] != '0)
        begin
            srv_q = Q_TOP;
        end
        else if (cnt_reg[Q_MIDDLE] != '0)
        begin
            srv_q = Q_MIDDLE;
        end
        else
        begin
            srv_q = Q_BOTTOM;
        end

        srv_ent   = head_ent[srv_q];
        time_dec  = (srv_ent.rem != '0) ? srv_ent.rem - 1'b1 : '0;
        svc_inc   = (srv_ent.svc < SVC_MAX) ? srv_ent.svc + 1'b1 : srv_ent.svc;
        limit_eff = (limit_reg == '0) ? SVC_W'(1) : limit_reg;
        demote    = (srv_q != Q_BOTTOM) && (svc_inc >= limit_eff);

        pop_en   = 1'b0;
        push_en  = 1'b0;
        push_q   = add_q;
        push_ent = '{pid: req.data.proc_id, rem: req.data.run_time, svc: '0};
        rsp_data_next = '{status: ST_IDLE, served_id: '0, served_level: LVL_NONE,
                          time_left: '0};

        if (req.data.func == FUNC_ADD)
        begin
            if (full)
            begin
                rsp_data_next.status = ST_FULL;
            end
            else
            begin
                rsp_data_next.status = ST_ADDED;
                push_en = in_fire;
            end
        end
        else if (any_held)
        begin
            pop_en = in_fire;
            rsp_data_next.served_id = srv_ent.pid;
            rsp_data_next.time_left = time_dec;
            case (srv_q)
                Q_TOP:    rsp_data_next.served_level = LVL_TOP;
                Q_MIDDLE: rsp_data_next.served_level = LVL_MIDDLE;
                default:  rsp_data_next.served_level = LVL_BOTTOM;
            endcase
            if (time_dec == '0)
            begin
                rsp_data_next.status = ST_FINISHED;
            end
            else
            begin
                rsp_data_next.status = ST_PENDING;
                push_en = in_fire;
                if (demote)
                begin
                    push_q   = srv_q - 2'd1;
                    push_ent = '{pid: srv_ent.pid, rem: time_dec, svc: '0};
                end
                else
                begin
                    push_q   = srv_q;
                    push_ent = '{pid: srv_ent.pid, rem: time_dec, svc: svc_inc};
                end
            end
        end
    end

    // Per-queue pointer and fill updates.
    always_comb
    begin
        for (int q = 0; q < 3; q++)
        begin
            slot_sum[q] = SW'(head_reg[q]) + SW'(cnt_reg[q]);
            if (slot_sum[q] >= SW'(DEPTH))
            begin
                slot_sum[q] = slot_sum[q] - SW'(DEPTH);
            end
            tail_slot[q] = slot_sum[q][AW-1:0];
            push_we[q]   = push_en && (push_q == 2'(q));

            head_next[q] = head_reg[q];
            cnt_next[q]  = cnt_reg[q];
            if (pop_en && (srv_q == 2'(q)))
            begin
                head_next[q] = (head_reg[q] == AW'(DEPTH - 1)) ? '0 : head_reg[q] + 1'b1;
                if (!push_we[q])
                begin
                    cnt_next[q] = cnt_reg[q] - 1'b1;
                end
            end
            else if (push_we[q])
            begin
                cnt_next[q] = cnt_reg[q] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_DEFAULT;
            rsp_valid_reg <= 1'b0;
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q] <= '0;
                cnt_reg[q]  <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                limit_reg <= cfg.data;
            end
            if (in_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            for (int q = 0; q < 3; q++)
            begin
                head_reg[q] <= head_next[q];
                cnt_reg[q]  <= cnt_next[q];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    `TLFS_NEVER(a_total_bound, total > TW'(DEPTH), "queues hold more than DEPTH entries")
    `TLFS_ASSERT(a_add_grows, in_fire && (req.data.func == FUNC_ADD) && !full |=> total == $past(total) + 1'b1, "accepted add did not grow the total")
    `TLFS_ASSERT(a_sched_no_grow, in_fire && (req.data.func == FUNC_SCHED) |=> total <= $past(total), "schedule beat grew the total")
    `TLFS_ASSERT(a_idle_empty, in_fire && (req.data.func == FUNC_SCHED) && !any_held |=> rsp_data_reg.status == ST_IDLE, "schedule on empty queues did not report idle")

endmodule

`default_nettype wire

FILE: tb/tb_three_level_feedback_scheduler_top.sv
`timescale 1ns / 100ps
// Self-checking testbench that predicts every scheduler result and compares each beat.
module tb_three_level_feedback_scheduler_top;
    import tlfs_pkg::*;

    localparam int HOLD_MAX = DEPTH_DEFAULT;

    logic clk;
    logic rst_n;

    tlfs_req_if req_ch ();
    tlfs_rsp_if rsp_ch ();
    tlfs_cfg_if cfg_ch ();

    three_level_feedback_scheduler_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Predicted queue contents and demotion limit.
    entry_t           top_q[$];
    entry_t           mid_q[$];
    bottom_entry_t    bot_q[$];
    logic [SVC_W-1:0] demote_limit = LIMIT_DEFAULT;

    rsp_t pending_rsp[$];
    int   fail_count = 0;
    bit   jitter_on = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int held_total();
        return top_q.size() + mid_q.size() + bot_q.size();
    endfunction

    // Applies one request to the predicted queues and returns the result it must produce.
    function automatic rsp_t schedule_step(req_t r);
        rsp_t             res;
        entry_t           e;
        bottom_entry_t    b;
        logic [SVC_W-1:0] lim;
        res = '0;
        e   = '0;
        if (r.func == FUNC_ADD)
        begin
            if (held_total() >= HOLD_MAX)
                res.status = ST_FULL;
            else
            begin
                res.status = ST_ADDED;
                e = '{pid: r.proc_id, rem: r.run_time, svc: '0};
                if (r.priority_level == LVL_BOTTOM)
                    bot_q.push_back('{pid: r.proc_id, rem: r.run_time});
                else if (r.priority_level == LVL_MIDDLE)
                    mid_q.push_back(e);
                else
                    top_q.push_back(e);
            end
        end
        else
        begin
            res.status = ST_IDLE;
            if (top_q.size() != 0)
            begin
                e = top_q.pop_front();
                res.served_level = LVL_TOP;
            end
            else if (mid_q.size() != 0)
            begin
                e = mid_q.pop_front();
                res.served_level = LVL_MIDDLE;
            end
            else if (bot_q.size() != 0)
            begin
                b = bot_q.pop_front();
                e = '{pid: b.pid, rem: b.rem, svc: '0};
                res.served_level = LVL_BOTTOM;
            end
            if (res.served_level != LVL_NONE)
            begin
                // A limit of zero behaves as a limit of one.
                lim = (demote_limit == '0) ? 4'd1 : demote_limit;
                if (e.rem != '0)
                    e.rem = e.rem - 1'b1;
                if (e.svc != SVC_MAX)
                    e.svc = e.svc + 1'b1;
                res.served_id = e.pid;
                res.time_left = e.rem;
                if (e.rem == '0)
                    res.status = ST_FINISHED;
                else
                begin
                    res.status = ST_PENDING;
                    if (res.served_level == LVL_BOTTOM)
                        bot_q.push_back('{pid: e.pid, rem: e.rem});
                    else if (e.svc < lim)
                    begin
                        if (res.served_level == LVL_TOP)
                            top_q.push_back(e);
                        else
                            mid_q.push_back(e);
                    end
                    else
                    begin
                        e.svc = '0;
                        if (res.served_level == LVL_TOP)
                            mid_q.push_back(e);
                        else
                            bot_q.push_back('{pid: e.pid, rem: e.rem});
                    end
                end
            end
        end
        return res;
    endfunction

    function automatic req_t make_req(logic fn, logic [ID_W-1:0] id,
                                      logic [TIME_W-1:0] run, logic [LVL_W-1:0] lvl);
        req_t r;
        r.func           = fn;
        r.proc_id        = id;
        r.run_time       = run;
        r.priority_level = lvl;
        return r;
    endfunction

    function automatic req_t sched_req();
        return make_req(FUNC_SCHED, ID_W'($urandom()), TIME_W'($urandom()),
                        LVL_W'($urandom()));
    endfunction

    function automatic req_t random_item(int add_pct);
        req_t r;
        int   pick;
        r = sched_req();
        if ($urandom_range(0, 99) < add_pct)
            r.func = FUNC_ADD;
        // Mostly short jobs so that processes retire; a full-range time stays around for good.
        pick = $urandom_range(0, 199);
        if (pick < 10)
            r.run_time = '0;
        else if (pick < 199)
            r.run_time = TIME_W'($urandom_range(1, 12));
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            fail_count++;
            if (fail_count <= 40)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_item(input req_t item);
        if (jitter_on && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_rsp.push_back(schedule_step(item));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_limit(input logic [SVC_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        demote_limit = value;
    endtask

    // Idle schedule, all four level codes, field extremes, zero time and both demotions.
    task automatic test_basic_service();
        send_item(sched_req());
        send_item(make_req(FUNC_ADD, 16'h0000, 16'hFFFF, LVL_NONE));
        send_item(make_req(FUNC_ADD, 16'hFFFF, 16'h0000, LVL_TOP));
        send_item(make_req(FUNC_ADD, 16'h1234, 16'h0002, LVL_MIDDLE));
        send_item(make_req(FUNC_ADD, 16'h0005, 16'h0001, LVL_BOTTOM));
        repeat (8) send_item(sched_req());
    endtask

    // A process that has collected services demotes at once when the limit drops below them.
    task automatic test_lowered_limit();
        wait_drained();
        write_limit(4'd15);
        send_item(make_req(FUNC_ADD, 16'hA5A5, 16'd20, LVL_TOP));
        repeat (3) send_item(sched_req());
        wait_drained();
        write_limit(4'd0);
        repeat (2) send_item(sched_req());
    endtask

    // Fill the store, get one add rejected, then demote while every slot is taken.
    task automatic test_full_store();
        wait_drained();
        write_limit(4'd1);
        while (held_total() < HOLD_MAX)
            send_item(make_req(FUNC_ADD, ID_W'($urandom()), TIME_W'($urandom_range(2, 9)),
                               LVL_W'($urandom())));
        send_item(make_req(FUNC_ADD, ID_W'($urandom()), 16'd3, LVL_TOP));
        send_item(sched_req());
    endtask

    task automatic test_random_phases();
        logic [SVC_W-1:0] limits[6];
        int               add_pct;
        limits = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd15, 4'd2};
        foreach (limits[p])
        begin
            wait_drained();
            write_limit((p == 5) ? SVC_W'($urandom()) : limits[p]);
            add_pct = $urandom_range(35, 65);
            repeat (170) send_item(random_item(add_pct));
        end
    endtask

    // Back-to-back beats with both sides always ready.
    task automatic test_steady_stream();
        wait_drained();
        write_limit(LIMIT_DEFAULT);
        jitter_on = 1'b0;
        repeat (150) send_item(random_item(50));
    endtask

    initial
    begin : result_monitor
        rsp_t want;
        int   stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 40)
                        $display("%0t: unexpected result beat: expected none, actual status %0d",
                                 $time, rsp_ch.data.status);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    check_field("status", want.status, rsp_ch.data.status);
                    check_field("served_id", want.served_id, rsp_ch.data.served_id);
                    check_field("served_level", want.served_level, rsp_ch.data.served_level);
                    check_field("time_left", want.time_left, rsp_ch.data.time_left);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (jitter_on && $urandom_range(0, 6) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin : main_sequence
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        rsp_ch.ready <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_service();
        test_lowered_limit();
        test_full_store();
        test_random_phases();
        test_steady_stream();
        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
